@@ rtl/exact_substring_matcher_unit_macros.svh @@
// ============================================================================
// Assertion macros for the exact substring matcher
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ============================================================================
`ifndef EXACT_SUBSTRING_MATCHER_UNIT_MACROS_SVH
`define EXACT_SUBSTRING_MATCHER_UNIT_MACROS_SVH

// same-cycle implication
`define ESM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ESM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/esm_pkg.sv @@
// ============================================================================
// Exact substring matcher package
// Sizes, register indexes and the cell control type.
// ============================================================================
`timescale 1ns / 1ps

package esm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int CHAIN_LEN   = MAX_PATTERN - 1;
    localparam int LEN_W       = 6;
    localparam int POS_W       = 32;
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 64;
    localparam int PAT_WORDS   = 4;
    localparam int PAT_BYTES   = PAT_WORDS * WORD_W / BYTE_W;
    localparam int PAT_IDX_W   = $clog2(PAT_BYTES);
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_BASE  = 3'd5;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

@@ rtl/esm_cell.sv @@
// ============================================================================
// Window cell
// Holds one earlier text byte with its valid flag, passes it on to the next
// cell on every accepted beat and compares it with its expected pattern byte.
// ============================================================================
`timescale 1ns / 1ps

module esm_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  esm_pkg::cell_ctrl_t        ctrl,
    input  logic [esm_pkg::BYTE_W-1:0] byte_in,
    input  logic                       valid_in,
    input  logic [esm_pkg::BYTE_W-1:0] expect_byte,
    input  logic                       care,
    output logic [esm_pkg::BYTE_W-1:0] byte_out,
    output logic                       valid_out,
    output logic                       ok
);
    import esm_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic              valid_reg;
    logic              valid_next;

    always_comb
    begin
        byte_next  = ctrl.shift ? byte_in : byte_reg;
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_next = valid_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;
    assign ok        = !care || (valid_reg && (byte_reg == expect_byte));

endmodule

@@ rtl/esm_out_stage.sv @@
// ============================================================================
// Result output register
// Holds one match position beat until the master side takes it.
// ============================================================================
`timescale 1ns / 1ps

module esm_out_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic [esm_pkg::POS_W-1:0] load_data,
    output logic                      room,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [esm_pkg::POS_W-1:0] m_axis_tdata   // [31:0] match_position
);
    import esm_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [POS_W-1:0] data_reg;
    logic [POS_W-1:0] data_next;

    assign room = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = load_data;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule

@@ rtl/exact_substring_matcher_unit.sv @@
// ============================================================================
// Exact substring matcher
// Streams text bytes past a window of cells and reports every occurrence of
// the configured pattern by its start position plus a base offset.
// ============================================================================
// The block takes one text byte per clock and can accept a byte on every
// cycle while the result register is empty or being drained; a match
// position appears on the master side the cycle after the byte that ends the
// match. The whole window is compared in parallel, so the rate is set only
// by the single output register. Every occurrence is reported, overlapping
// ones too. A beat with tlast ends the text: its own match is still reported,
// then the position counter and the window clear. Configuration writes are
// always taken and must be made while no text is in flight.
`timescale 1ns / 1ps

`include "exact_substring_matcher_unit_macros.svh"

module exact_substring_matcher_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [esm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [esm_pkg::WORD_W-1:0]    cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [esm_pkg::BYTE_W-1:0]    s_axis_tdata,   // [7:0] text_byte
    input  logic                          s_axis_tlast,   // last_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [esm_pkg::POS_W-1:0]     m_axis_tdata    // [31:0] match_position
);
    import esm_pkg::*;

    logic [LEN_W-1:0]                  pattern_length_reg;
    logic [LEN_W-1:0]                  pattern_length_next;
    logic [PAT_WORDS-1:0][WORD_W-1:0]  pattern_reg;
    logic [PAT_WORDS-1:0][WORD_W-1:0]  pattern_next;
    logic [POS_W-1:0]                  position_base_reg;
    logic [POS_W-1:0]                  position_base_next;
    logic [POS_W-1:0]                  bytes_seen_reg;
    logic [POS_W-1:0]                  bytes_seen_next;

    logic [PAT_BYTES-1:0][BYTE_W-1:0]  pat_bytes;
    logic [LEN_W-1:0]                  len_eff;
    logic [LEN_W-1:0]                  idx0;
    logic [POS_W-1:0]                  pos_offset;
    logic [POS_W-1:0]                  match_pos;
    logic                              accept;
    logic                              room;
    logic                              hit;
    logic                              eq0;
    cell_ctrl_t                        ctrl;

    logic [CHAIN_LEN-1:0][BYTE_W-1:0]  chain_byte;
    logic [CHAIN_LEN-1:0]              chain_valid;
    logic [CHAIN_LEN-1:0]              chain_ok;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        pattern_length_next = pattern_length_reg;
        pattern_next        = pattern_reg;
        position_base_next  = position_base_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PATTERN_LENGTH: pattern_length_next = cfg_data[LEN_W-1:0];
                CFG_PATTERN_WORD_0: pattern_next[0]     = cfg_data;
                CFG_PATTERN_WORD_1: pattern_next[1]     = cfg_data;
                CFG_PATTERN_WORD_2: pattern_next[2]     = cfg_data;
                CFG_PATTERN_WORD_3: pattern_next[3]     = cfg_data;
                CFG_POSITION_BASE:  position_base_next  = cfg_data[POS_W-1:0];
                default:            pattern_length_next = pattern_length_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= LEN_W'(1);
            pattern_reg        <= '0;
            position_base_reg  <= '0;
            bytes_seen_reg     <= '0;
        end
        else
        begin
            pattern_length_reg <= pattern_length_next;
            pattern_reg        <= pattern_next;
            position_base_reg  <= position_base_next;
            bytes_seen_reg     <= bytes_seen_next;
        end
    end

    assign pat_bytes = pattern_reg;
    assign len_eff   = (pattern_length_reg > LEN_W'(MAX_PATTERN)) ?
                       LEN_W'(MAX_PATTERN) : pattern_length_reg;

    // stream handshake and cell control
    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign ctrl.shift    = accept;
    assign ctrl.clear    = accept && s_axis_tlast;

    always_comb
    begin
        bytes_seen_next = bytes_seen_reg;
        if (accept)
        begin
            bytes_seen_next = s_axis_tlast ? '0 : bytes_seen_reg + POS_W'(1);
        end
    end

    // window chain
    genvar c;
    generate
        for (c = 0; c < CHAIN_LEN; c++)
        begin : g_cell
            logic [LEN_W-1:0]  pat_idx;
            logic [BYTE_W-1:0] link_byte;
            logic              link_valid;
            logic              cell_care;

            assign pat_idx   = len_eff - LEN_W'(c + 1) - LEN_W'(1);
            assign cell_care = LEN_W'(c + 1) < len_eff;

            if (c == 0)
            begin : g_head
                assign link_byte  = s_axis_tdata;
                assign link_valid = 1'b1;
            end
            else
            begin : g_body
                assign link_byte  = chain_byte[c-1];
                assign link_valid = chain_valid[c-1];
            end

            esm_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .byte_in     (link_byte),
                .valid_in    (link_valid),
                .expect_byte (pat_bytes[pat_idx[PAT_IDX_W-1:0]]),
                .care        (cell_care),
                .byte_out    (chain_byte[c]),
                .valid_out   (chain_valid[c]),
                .ok          (chain_ok[c])
            );
        end
    endgenerate

    // newest byte against the last pattern byte in use
    assign idx0 = len_eff - LEN_W'(1);
    assign eq0  = s_axis_tdata == pat_bytes[idx0[PAT_IDX_W-1:0]];
    assign hit  = (len_eff != '0) && eq0 && (&chain_ok);

    assign pos_offset = position_base_reg + POS_W'(1) - POS_W'(len_eff);
    assign match_pos  = bytes_seen_reg + pos_offset;

    esm_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept && hit),
        .load_data     (match_pos),
        .room          (room),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    `ESM_ASSERT_SAME(a_ready_when_empty, !m_axis_tvalid, s_axis_tready,
        "input stalled with an empty result register")
    `ESM_ASSERT_NEXT(a_count_clear, accept && s_axis_tlast, bytes_seen_reg == '0,
        "position counter not cleared after end of text")
    `ESM_ASSERT_NEXT(a_window_clear, accept && s_axis_tlast, chain_valid == '0,
        "window not cleared after end of text")
    `ESM_ASSERT_SAME(a_zero_len, len_eff == '0, !hit,
        "match reported for an empty pattern")

endmodule

@@ tb/tb_top.sv @@
// ============================================================================
// Exact substring matcher testbench
// Streams framed text bytes through the matcher under changing pattern,
// length and base settings, with random gaps on both stream sides. A local
// window model predicts every match position, and the master-side beats are
// checked against those positions in order.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
    import esm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int ITEM_TARGET = 1350;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } text_beat_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [WORD_W-1:0]    cfg_data      = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [BYTE_W-1:0]    s_axis_tdata  = '0;   // [7:0] text_byte
    logic                 s_axis_tlast  = 1'b0; // last_byte
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [POS_W-1:0]     m_axis_tdata;         // [31:0] match_position

    exact_substring_matcher_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // matcher model: settings and window
    logic [BYTE_W-1:0] pat_mem [0:PAT_BYTES-1];
    logic [LEN_W-1:0]  pat_len    = 6'd1;
    logic [POS_W-1:0]  pos_base   = '0;
    logic [BYTE_W-1:0] win_bytes [0:CHAIN_LEN-1];
    logic [POS_W-1:0]  seen_count = '0;
    int                win_fill   = 0;

    text_beat_t       text_queue [$];
    logic [POS_W-1:0] pending_positions [$];

    int n_pushed  = 0;
    int n_bytes   = 0;
    int n_frames  = 0;
    int n_matches = 0;
    int n_phases  = 0;
    int n_errors  = 0;

    initial
    begin
        foreach (pat_mem[i])
            pat_mem[i] = '0;
        foreach (win_bytes[i])
            win_bytes[i] = '0;
    end

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
        int b;
        int word;
        case (idx)
            CFG_PATTERN_LENGTH:
                pat_len = value[LEN_W-1:0];
            CFG_PATTERN_WORD_0, CFG_PATTERN_WORD_1, CFG_PATTERN_WORD_2, CFG_PATTERN_WORD_3:
            begin
                word = int'(idx) - int'(CFG_PATTERN_WORD_0);
                for (b = 0; b < 8; b++)
                    pat_mem[word * 8 + b] = value[8 * b +: 8];
            end
            CFG_POSITION_BASE:
                pos_base = value[POS_W-1:0];
            default:
                ;
        endcase
    endfunction

    function automatic void scan_byte(logic [BYTE_W-1:0] t, logic last);
        int               span;
        int               k;
        logic             hit;
        logic [POS_W-1:0] pos;
        span = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
        hit  = 1'b0;
        if (span >= 1 && win_fill >= span - 1)
        begin
            hit = (pat_mem[span-1] == t);
            for (k = 1; k < span; k++)
                if (pat_mem[span-1-k] != win_bytes[k-1])
                    hit = 1'b0;
        end
        if (hit)
        begin
            pos = seen_count - POS_W'(span - 1) + pos_base;
            pending_positions.insert(pending_positions.size(), pos);
        end
        for (k = CHAIN_LEN - 1; k > 0; k--)
            win_bytes[k] = win_bytes[k-1];
        win_bytes[0] = t;
        if (win_fill < CHAIN_LEN)
            win_fill++;
        seen_count++;
        if (last)
        begin
            seen_count = '0;
            win_fill   = 0;
            for (k = 0; k < CHAIN_LEN; k++)
                win_bytes[k] = '0;
        end
    endfunction

    // text driver
    int   send_gap   = 0;
    logic beat_busy  = 1'b0;
    logic send_burst = 1'b0;

    always @(posedge clk)
    begin
        text_beat_t beat;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                scan_byte(s_axis_tdata, s_axis_tlast);
                n_bytes++;
                if (s_axis_tlast)
                    n_frames++;
                beat_busy = 1'b0;
            end
            if (!beat_busy)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (text_queue.size() != 0)
                begin
                    beat = text_queue.pop_front();
                    s_axis_tdata <= beat.data;
                    s_axis_tlast <= beat.last;
                    beat_busy = 1'b1;
                    if ($urandom_range(0, 47) == 0)
                        send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 11);
                end
            end
            s_axis_tvalid <= beat_busy;
        end
    end

    // result monitor
    int   recv_gap   = 0;
    logic recv_burst = 1'b0;

    always @(posedge clk)
    begin
        logic [POS_W-1:0] want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_matches++;
                if (pending_positions.size() == 0)
                begin
                    $error("unexpected beat: match_position %0h", m_axis_tdata);
                    n_errors++;
                end
                else
                begin
                    want = pending_positions.pop_front();
                    if (want !== m_axis_tdata)
                    begin
                        $error("match_position: expected %0h, got %0h", want, m_axis_tdata);
                        n_errors++;
                    end
                end
                if ($urandom_range(0, 31) == 0)
                    recv_burst = !recv_burst;
                recv_gap = recv_burst ? 0 : $urandom_range(0, 11);
            end
            else if (recv_gap > 0)
                recv_gap--;
            m_axis_tready <= (recv_gap == 0);
        end
    end

    // watchdog
    int quiet = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $error("no beat moved for %0d cycles", quiet);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, value);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (text_queue.size() != 0 || beat_busy || pending_positions.size() != 0);
        repeat (4) @(posedge clk);
        n_phases++;
    endtask

    task automatic push_beat(logic [BYTE_W-1:0] data, logic last);
        text_beat_t beat;
        beat.data = data;
        beat.last = last;
        text_queue.insert(text_queue.size(), beat);
        n_pushed++;
    endtask

    function automatic logic [BYTE_W-1:0] noise_byte(int span);
        logic [BYTE_W-1:0] v;
        case ($urandom_range(0, 3))
            0, 1:
                v = (span > 0) ? pat_mem[$urandom_range(0, span - 1)] : BYTE_W'($urandom);
            2:
                v = BYTE_W'($urandom);
            default:
                v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
        return v;
    endfunction

    task automatic add_frame(int span);
        text_beat_t frame [$];
        text_beat_t beat;
        int         goal;
        int         cut;
        int         i;
        goal = $urandom_range(1, 48);
        beat.last = 1'b0;
        while (frame.size() < goal)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                    cut = span;
                6, 7:
                    cut = (span > 1) ? $urandom_range(0, span - 1) : 0;
                default:
                    cut = 0;
            endcase
            for (i = 0; i < cut; i++)
            begin
                beat.data = pat_mem[i];
                frame.insert(frame.size(), beat);
            end
            if (cut < span || span == 0)
                for (i = $urandom_range(1, 3); i > 0; i--)
                begin
                    beat.data = noise_byte(span);
                    frame.insert(frame.size(), beat);
                end
        end
        frame[frame.size() - 1].last = 1'b1;
        foreach (frame[j])
            push_beat(frame[j].data, frame[j].last);
    endtask

    task automatic random_phase();
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] sym_a;
        logic [BYTE_W-1:0] sym_b;
        logic [BYTE_W-1:0] fill;
        logic [BYTE_W-1:0] v;
        logic [WORD_W-1:0] words [0:PAT_WORDS-1];
        logic [POS_W-1:0]  base;
        int                mode;
        int                span;
        int                goal;
        int                start;
        int                i;
        case ($urandom_range(0, 19))
            0:       len = 6'd0;
            1:       len = 6'd1;
            2:       len = 6'd32;
            3:       len = LEN_W'($urandom_range(33, 63));
            4, 5, 6, 7, 8, 9:
                     len = LEN_W'($urandom_range(2, 31));
            default: len = LEN_W'($urandom_range(2, 6));
        endcase
        mode  = $urandom_range(0, 9);
        sym_a = BYTE_W'($urandom);
        sym_b = BYTE_W'($urandom);
        fill  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        for (i = 0; i < PAT_BYTES; i++)
        begin
            if (mode <= 5)
                v = $urandom_range(0, 1) ? sym_a : sym_b;
            else if (mode <= 8)
                v = BYTE_W'($urandom);
            else
                v = fill;
            words[i / 8][8 * (i % 8) +: 8] = v;
        end
        case ($urandom_range(0, 4))
            0:       base = '0;
            1:       base = 32'hFFFF_FFFF - POS_W'($urandom_range(0, 40));
            default: base = $urandom;
        endcase

        write_reg(CFG_PATTERN_LENGTH, WORD_W'(len));
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7, {$urandom, $urandom});
        write_reg(CFG_PATTERN_WORD_0, words[0]);
        write_reg(CFG_PATTERN_WORD_1, words[1]);
        write_reg(CFG_PATTERN_WORD_2, words[2]);
        write_reg(CFG_PATTERN_WORD_3, words[3]);
        write_reg(CFG_POSITION_BASE, WORD_W'(base));

        span  = (len > MAX_PATTERN) ? MAX_PATTERN : int'(len);
        goal  = $urandom_range(40, 110);
        start = n_pushed;
        while (n_pushed - start < goal)
            add_frame(span);
        wait_drained();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: one zero byte, matches on the last beat too
        push_beat(8'h00, 1'b1);
        push_beat(8'hFF, 1'b0);
        push_beat(8'h00, 1'b1);
        wait_drained();

        // overlapping hits, early end of text, position wrap
        write_reg(CFG_PATTERN_LENGTH, 64'd2);
        write_reg(CFG_PATTERN_WORD_0, 64'h6161);
        write_reg(CFG_POSITION_BASE, 64'hFFFF_FFFE);
        push_beat(8'h61, 1'b1);
        push_beat(8'h61, 1'b0);
        push_beat(8'h61, 1'b0);
        push_beat(8'h61, 1'b0);
        push_beat(8'h61, 1'b1);
        push_beat(8'h61, 1'b1);
        wait_drained();

        // zero length never hits
        write_reg(CFG_PATTERN_LENGTH, 64'd0);
        push_beat(8'h61, 1'b0);
        push_beat(8'h61, 1'b1);
        wait_drained();

        // writes to unmapped indexes leave the settings alone; new length, word 0 and base follow
        write_reg(CFG_SPARE_6, '0);
        write_reg(CFG_SPARE_7, '1);
        write_reg(CFG_PATTERN_LENGTH, 64'd5);
        write_reg(CFG_PATTERN_WORD_0, '1);
        write_reg(CFG_POSITION_BASE, 64'd0);
        repeat (5) push_beat(8'hFF, 1'b0);
        push_beat(8'hFF, 1'b1);
        wait_drained();

        while (n_pushed < ITEM_TARGET)
            random_phase();

        $display("Scanned %0d text bytes in %0d frames under %0d pattern settings",
                 n_bytes, n_frames, n_phases);
        $display("Checked %0d match positions, pattern lengths 0 to 63", n_matches);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/esm_pkg.sv
rtl/esm_cell.sv
rtl/esm_out_stage.sv
rtl/exact_substring_matcher_unit.sv
tb/tb_top.sv
